FILE: sv/gsp_pkg.sv
// Shared types and constants for the grid maze waypoint shortest path core.
`default_nettype none

package gsp_pkg;

    // Widths fixed by the register map and the result format
    localparam int CFG_W  = 8;
    localparam int DIST_W = 15;

    // Cell codes (codes above the exit code load as open cells)
    localparam logic [2:0] CODE_WALL  = 3'd1;
    localparam logic [2:0] CODE_START = 3'd2;
    localparam logic [2:0] CODE_LEVER = 3'd3;
    localparam logic [2:0] CODE_EXIT  = 3'd4;

    // Register indexes
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0]  SIDE_RESET = 8'd128;
    localparam logic [DIST_W-1:0] DIST_MAX   = 15'h7FFF;

    typedef enum logic [1:0] {
        NB_LEFT,
        NB_RIGHT,
        NB_DOWN,
        NB_UP
    } nb_dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLEAR,
        ST_DIV,
        ST_DIV_WAIT,
        ST_INIT,
        ST_POP,
        ST_CUR_IDX,
        ST_DIST_WAIT,
        ST_NB_RD,
        ST_NB_CHK,
        ST_FIN
    } gsp_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    search_begin;
        logic    phase_next;
        logic    clr_step;
        logic    div_start;
        logic    init;
        logic    pop;
        logic    cur_load;
        logic    nb_commit;
        logic    out_load;
        nb_dir_t nb_sel;
    } gsp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic markers_ok;
        logic clr_last;
        logic div_done;
        logic queue_empty;
        logic nb_valid;
        logic nb_free;
        logic nb_hit;
        logic phase;
        logic out_busy;
    } gsp_stat_t;

endpackage

`default_nettype wire

FILE: sv/gsp_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module gsp_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  busy,
    output logic [NUM_W-1:0]      quotient,
    output logic [DEN_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end
        else if (start) begin
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0) begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
        end
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: sv/gsp_datapath.sv
// Datapath: config registers, grid memories, search queue and result register.
`default_nettype none

module gsp_datapath #(
    parameter int MAX_SIDE = 128
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic                      cfg_index,
    input  wire logic [gsp_pkg::CFG_W-1:0] cfg_data,
    input  wire logic [2:0]                cell_code,
    input  wire logic                      last_cell,
    input  wire gsp_pkg::gsp_cmd_t         cmd,
    output gsp_pkg::gsp_stat_t             stat,
    input  wire logic                      out_stall,
    output logic                           out_valid,
    output logic                           reachable,
    output logic [gsp_pkg::DIST_W-1:0]     path_length
);

    localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = CW + 1;
    localparam int DW = gsp_pkg::DIST_W;

    function automatic logic [SW-1:0] clamp_side(input logic [gsp_pkg::CFG_W-1:0] v);
        logic [31:0] t;
        begin
            t = 32'(v);
            if (v == '0) t = 32'd1;
            else if (t > 32'(MAX_SIDE)) t = 32'(MAX_SIDE);
            return t[SW-1:0];
        end
    endfunction

    // Config and load state
    logic [gsp_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [SW-1:0]  w_side, h_side;
    logic [2*SW-1:0] size_prod;
    logic [AW:0]    size;
    logic [AW:0]    load_idx_reg;
    logic           in_range;
    logic [AW-1:0]  start_pos_reg, lever_pos_reg, exit_pos_reg;
    logic           start_seen_reg, lever_seen_reg, exit_seen_reg;
    logic           all_seen;

    // Search state
    logic [AW-1:0]  src_reg, dst_reg, exit_hold_reg;
    logic           phase_reg;
    logic [AW:0]    clr_reg, head_reg, tail_reg;
    logic [CW-1:0]  cur_row_reg, cur_col_reg;
    logic [AW-1:0]  cur_idx_reg;
    logic [CW-1:0]  nb_row_reg, nb_col_reg;
    logic [AW-1:0]  nb_idx_reg;
    logic           res_ok_reg;
    logic [DW-1:0]  res_len_reg;

    // Memories and their registered read data
    logic           wall_mem  [CELL_COUNT];
    logic           vis_mem   [CELL_COUNT];
    logic [2*CW-1:0] queue_mem [CELL_COUNT];
    logic [DW-1:0]  dist_mem  [CELL_COUNT];
    logic           wall_rd_reg, vis_rd_reg;
    logic [2*CW-1:0] q_rd_reg;
    logic [DW-1:0]  dist_rd_reg;

    // Neighbor and divider signals
    logic           nb_ok;
    logic [AW-1:0]  nb_p;
    logic [CW-1:0]  nb_r, nb_c;
    logic [CW+SW-1:0] cur_prod;
    logic [DW-1:0]  dist_new;
    logic           div_busy;
    logic [AW-1:0]  div_q;
    logic [SW-1:0]  div_r;

    logic           vis_we, vis_wdata, q_we, dist_we;
    logic [AW-1:0]  vis_waddr, q_waddr, dist_waddr;
    logic [2*CW-1:0] q_wdata;
    logic [DW-1:0]  dist_wdata;

    assign w_side    = clamp_side(width_reg);
    assign h_side    = clamp_side(height_reg);
    assign size_prod = (2*SW)'(w_side) * (2*SW)'(h_side);
    assign size      = size_prod[AW:0];
    assign in_range  = load_idx_reg < size;
    assign all_seen  = start_seen_reg && lever_seen_reg && exit_seen_reg;

    // Row and column of the source cell
    gsp_div #(
        .NUM_W (AW),
        .DEN_W (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (src_reg),
        .divisor   (w_side),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Select the neighbor under test
    always_comb begin
        nb_ok = 1'b0;
        nb_p  = cur_idx_reg;
        nb_r  = cur_row_reg;
        nb_c  = cur_col_reg;
        unique case (cmd.nb_sel)
            gsp_pkg::NB_LEFT: begin
                nb_ok = cur_col_reg != '0;
                nb_p  = cur_idx_reg - AW'(1);
                nb_c  = cur_col_reg - CW'(1);
            end
            gsp_pkg::NB_RIGHT: begin
                nb_ok = (SW'(cur_col_reg) + SW'(1)) < w_side;
                nb_p  = cur_idx_reg + AW'(1);
                nb_c  = cur_col_reg + CW'(1);
            end
            gsp_pkg::NB_DOWN: begin
                nb_ok = (SW'(cur_row_reg) + SW'(1)) < h_side;
                nb_p  = cur_idx_reg + AW'(w_side);
                nb_r  = cur_row_reg + CW'(1);
            end
            gsp_pkg::NB_UP: begin
                nb_ok = cur_row_reg != '0;
                nb_p  = cur_idx_reg - AW'(w_side);
                nb_r  = cur_row_reg - CW'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign cur_prod = (CW+SW)'(q_rd_reg[2*CW-1:CW]) * (CW+SW)'(w_side)
                    + (CW+SW)'(q_rd_reg[CW-1:0]);
    assign dist_new = (dist_rd_reg == gsp_pkg::DIST_MAX) ? gsp_pkg::DIST_MAX
                                                         : dist_rd_reg + DW'(1);

    // Write port selection
    always_comb begin
        vis_we     = cmd.clr_step || cmd.init || cmd.nb_commit;
        vis_waddr  = nb_idx_reg;
        vis_wdata  = 1'b1;
        priority if (cmd.clr_step) begin
            vis_waddr = clr_reg[AW-1:0];
            vis_wdata = 1'b0;
        end
        else if (cmd.init) begin
            vis_waddr = src_reg;
        end
        q_we       = cmd.init || cmd.nb_commit;
        q_waddr    = cmd.init ? '0 : tail_reg[AW-1:0];
        q_wdata    = cmd.init ? {div_q[CW-1:0], div_r[CW-1:0]} : {nb_row_reg, nb_col_reg};
        dist_we    = (cmd.init && !phase_reg) || cmd.nb_commit;
        dist_waddr = cmd.init ? src_reg : nb_idx_reg;
        dist_wdata = cmd.init ? '0 : dist_new;
    end

    // Memories
    always_ff @(posedge clk) begin
        if (cmd.load && in_range) begin
            wall_mem[load_idx_reg[AW-1:0]] <= cell_code == gsp_pkg::CODE_WALL;
        end
        wall_rd_reg <= wall_mem[nb_p];
    end

    always_ff @(posedge clk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_rd_reg <= vis_mem[nb_p];
    end

    always_ff @(posedge clk) begin
        if (q_we) begin
            queue_mem[q_waddr] <= q_wdata;
        end
        q_rd_reg <= queue_mem[head_reg[AW-1:0]];
    end

    always_ff @(posedge clk) begin
        if (dist_we) begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rd_reg <= dist_mem[cur_idx_reg];
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  <= gsp_pkg::SIDE_RESET;
            height_reg <= gsp_pkg::SIDE_RESET;
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                gsp_pkg::REG_GRID_WIDTH:  width_reg  <= cfg_data;
                gsp_pkg::REG_GRID_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Load index and marker flags
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            load_idx_reg   <= '0;
            start_seen_reg <= 1'b0;
            lever_seen_reg <= 1'b0;
            exit_seen_reg  <= 1'b0;
        end
        else if (cmd.load) begin
            if (last_cell) begin
                load_idx_reg <= '0;
            end
            else if (load_idx_reg < (AW+1)'(CELL_COUNT)) begin
                load_idx_reg <= load_idx_reg + (AW+1)'(1);
            end
            if (in_range && !all_seen) begin
                if (cell_code == gsp_pkg::CODE_START) start_seen_reg <= 1'b1;
                if (cell_code == gsp_pkg::CODE_LEVER) lever_seen_reg <= 1'b1;
                if (cell_code == gsp_pkg::CODE_EXIT)  exit_seen_reg  <= 1'b1;
            end
        end
        else if (cmd.search_begin) begin
            start_seen_reg <= 1'b0;
            lever_seen_reg <= 1'b0;
            exit_seen_reg  <= 1'b0;
        end
    end

    // Marker positions
    always_ff @(posedge clk) begin
        if (cmd.load && in_range && !all_seen) begin
            if (cell_code == gsp_pkg::CODE_START) start_pos_reg <= load_idx_reg[AW-1:0];
            if (cell_code == gsp_pkg::CODE_LEVER) lever_pos_reg <= load_idx_reg[AW-1:0];
            if (cell_code == gsp_pkg::CODE_EXIT)  exit_pos_reg  <= load_idx_reg[AW-1:0];
        end
    end

    // Search control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg  <= 1'b0;
            clr_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            res_ok_reg <= 1'b0;
        end
        else begin
            if (cmd.search_begin) begin
                phase_reg  <= 1'b0;
                res_ok_reg <= 1'b0;
            end
            else if (cmd.phase_next) begin
                phase_reg <= 1'b1;
            end
            else if (cmd.nb_commit && nb_idx_reg == dst_reg && phase_reg) begin
                res_ok_reg <= 1'b1;
            end
            if (cmd.search_begin || cmd.phase_next) begin
                clr_reg <= '0;
            end
            else if (cmd.clr_step) begin
                clr_reg <= clr_reg + (AW+1)'(1);
            end
            if (cmd.init) begin
                head_reg <= '0;
                tail_reg <= (AW+1)'(1);
            end
            else begin
                if (cmd.pop) head_reg <= head_reg + (AW+1)'(1);
                if (cmd.nb_commit) tail_reg <= tail_reg + (AW+1)'(1);
            end
        end
    end

    // Search payload registers
    always_ff @(posedge clk) begin
        if (cmd.search_begin) begin
            src_reg       <= start_pos_reg;
            dst_reg       <= lever_pos_reg;
            exit_hold_reg <= exit_pos_reg;
        end
        else if (cmd.phase_next) begin
            src_reg <= dst_reg;
            dst_reg <= exit_hold_reg;
        end
        if (cmd.cur_load) begin
            cur_row_reg <= q_rd_reg[2*CW-1:CW];
            cur_col_reg <= q_rd_reg[CW-1:0];
            cur_idx_reg <= cur_prod[AW-1:0];
        end
        // Latch the neighbor during its read cycle
        nb_row_reg <= nb_r;
        nb_col_reg <= nb_c;
        nb_idx_reg <= nb_p;
        if (cmd.nb_commit && nb_idx_reg == dst_reg && phase_reg) begin
            res_len_reg <= dist_new;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid <= 1'b0;
        end
        else if (cmd.out_load) begin
            out_valid <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            reachable   <= res_ok_reg;
            path_length <= res_ok_reg ? res_len_reg : '0;
        end
    end

    // Status
    always_comb begin
        stat.markers_ok  = all_seen
                        && ({1'b0, start_pos_reg} < size)
                        && ({1'b0, lever_pos_reg} < size)
                        && ({1'b0, exit_pos_reg} < size);
        stat.clr_last    = clr_reg == (size - (AW+1)'(1));
        stat.div_done    = !div_busy;
        stat.queue_empty = head_reg == tail_reg;
        stat.nb_valid    = nb_ok;
        stat.nb_free     = !vis_rd_reg && !wall_rd_reg;
        stat.nb_hit      = nb_idx_reg == dst_reg;
        stat.phase       = phase_reg;
        stat.out_busy    = out_valid && out_stall;
    end

endmodule

`default_nettype wire

FILE: sv/gsp_ctrl.sv
// Controller: sequences loading, visit clearing and the two searches.
`default_nettype none

module gsp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               last_cell,
    input  wire gsp_pkg::gsp_stat_t stat,
    output gsp_pkg::gsp_cmd_t       cmd,
    output logic                    in_stall
);

    gsp_pkg::gsp_state_t state_reg, state_next;
    gsp_pkg::nb_dir_t    k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= gsp_pkg::ST_IDLE;
            k_reg     <= gsp_pkg::NB_LEFT;
        end
        else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            gsp_pkg::ST_IDLE: begin
                if (in_valid && last_cell) state_next = gsp_pkg::ST_CHECK;
            end
            gsp_pkg::ST_CHECK: begin
                state_next = stat.markers_ok ? gsp_pkg::ST_CLEAR : gsp_pkg::ST_FIN;
            end
            gsp_pkg::ST_CLEAR: begin
                if (stat.clr_last) state_next = gsp_pkg::ST_DIV;
            end
            gsp_pkg::ST_DIV: begin
                state_next = gsp_pkg::ST_DIV_WAIT;
            end
            gsp_pkg::ST_DIV_WAIT: begin
                if (stat.div_done) state_next = gsp_pkg::ST_INIT;
            end
            gsp_pkg::ST_INIT: begin
                state_next = gsp_pkg::ST_POP;
            end
            gsp_pkg::ST_POP: begin
                state_next = stat.queue_empty ? gsp_pkg::ST_FIN : gsp_pkg::ST_CUR_IDX;
            end
            gsp_pkg::ST_CUR_IDX: begin
                state_next = gsp_pkg::ST_DIST_WAIT;
            end
            gsp_pkg::ST_DIST_WAIT: begin
                state_next = gsp_pkg::ST_NB_RD;
                k_next     = gsp_pkg::NB_LEFT;
            end
            gsp_pkg::ST_NB_RD: begin
                priority if (stat.nb_valid) begin
                    state_next = gsp_pkg::ST_NB_CHK;
                end
                else if (k_reg == gsp_pkg::NB_UP) begin
                    state_next = gsp_pkg::ST_POP;
                end
                else begin
                    k_next = gsp_pkg::nb_dir_t'(k_reg + 2'd1);
                end
            end
            gsp_pkg::ST_NB_CHK: begin
                priority if (stat.nb_free && stat.nb_hit) begin
                    state_next = stat.phase ? gsp_pkg::ST_FIN : gsp_pkg::ST_CLEAR;
                end
                else if (k_reg == gsp_pkg::NB_UP) begin
                    state_next = gsp_pkg::ST_POP;
                end
                else begin
                    state_next = gsp_pkg::ST_NB_RD;
                    k_next     = gsp_pkg::nb_dir_t'(k_reg + 2'd1);
                end
            end
            gsp_pkg::ST_FIN: begin
                if (!stat.out_busy) state_next = gsp_pkg::ST_IDLE;
            end
            default: begin
                state_next = gsp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd          = '0;
        cmd.nb_sel   = k_reg;
        in_stall     = state_reg != gsp_pkg::ST_IDLE;
        unique case (state_reg)
            gsp_pkg::ST_IDLE:      cmd.load = in_valid;
            gsp_pkg::ST_CHECK:     cmd.search_begin = 1'b1;
            gsp_pkg::ST_CLEAR:     cmd.clr_step = 1'b1;
            gsp_pkg::ST_DIV:       cmd.div_start = 1'b1;
            gsp_pkg::ST_DIV_WAIT:  ;
            gsp_pkg::ST_INIT:      cmd.init = 1'b1;
            gsp_pkg::ST_POP:       cmd.pop = !stat.queue_empty;
            gsp_pkg::ST_CUR_IDX:   cmd.cur_load = 1'b1;
            gsp_pkg::ST_DIST_WAIT: ;
            gsp_pkg::ST_NB_RD:     ;
            gsp_pkg::ST_NB_CHK: begin
                cmd.nb_commit  = stat.nb_free;
                cmd.phase_next = stat.nb_free && stat.nb_hit && !stat.phase;
            end
            gsp_pkg::ST_FIN:       cmd.out_load = !stat.out_busy;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/grid_maze_waypoint_shortest_path_core.sv
// Top level of the grid maze waypoint shortest path core.
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_write            | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall  | cell_code, last_cell
//  out     | out       | out_valid / out_stall| reachable, path_length
//
// Cells load while the core is idle. The last cell starts the searches if start,
// lever and exit were all seen: each search first clears the visit marks of the
// width*height cells, then finds the source row and column with the divider, then
// pops each queued cell, reads its distance and tests its four neighbors.
// No clearing pass after reset.
// in_stall stays high from the last cell until the result sits in the output
// register; a stalled result holds and the next grid is accepted meanwhile.
`default_nettype none

module grid_maze_waypoint_shortest_path_core #(
    parameter int MAX_SIDE = 128
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic                      cfg_index,
    input  wire logic [gsp_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [2:0]                cell_code,
    input  wire logic                      last_cell,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           reachable,
    output logic [gsp_pkg::DIST_W-1:0]     path_length
);

    gsp_pkg::gsp_cmd_t  cmd;
    gsp_pkg::gsp_stat_t stat;

    gsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_cell (last_cell),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    gsp_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cell_code   (cell_code),
        .last_cell   (last_cell),
        .cmd         (cmd),
        .stat        (stat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .reachable   (reachable),
        .path_length (path_length)
    );

endmodule

`default_nettype wire

FILE: sv/gsp_checker.sv
// Port-level checks for the core, bound to the top level.
`default_nettype none

module gsp_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      last_cell,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic                      reachable,
    input wire logic [gsp_pkg::DIST_W-1:0] path_length
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(reachable) && $stable(path_length))
        else $error("stalled result changed");

    // Unreachable results carry no length
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reachable |-> path_length == '0)
        else $error("unreachable result with nonzero length");

    // Start, lever and exit are distinct cells, so a path has at least two steps
    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reachable |-> path_length > 15'd1)
        else $error("reachable result too short");

    // Stall input after the last cell transfer while searching
    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_cell |=> in_stall)
        else $error("input taken right after last cell");

endmodule

bind grid_maze_waypoint_shortest_path_core gsp_checker u_gsp_checker (.*);

`default_nettype wire
